### rtl/imusti_pkg.sv
`default_nettype none
package imusti_pkg;

    // Sample store geometry.
    localparam int FifoDepth = 16;
    localparam int SlotW     = $clog2(FifoDepth);
    localparam int CountW    = $clog2(FifoDepth + 1);

    // Field widths.
    localparam int StampW  = 32;
    localparam int CompW   = 16;
    localparam int NComp   = 10;
    localparam int GapW    = 24;
    localparam int StatusW = 3;
    localparam int SampleW = StampW + NComp * CompW;

    localparam logic [GapW-1:0] GapReset = 24'd200000;

    // Operation codes.
    localparam logic OpPush = 1'b0;
    localparam logic OpSync = 1'b1;

    // Result status codes.
    localparam logic [StatusW-1:0] StPushed  = 3'd0;
    localparam logic [StatusW-1:0] StDropped = 3'd1;
    localparam logic [StatusW-1:0] StSynced  = 3'd2;
    localparam logic [StatusW-1:0] StNoPair  = 3'd3;
    localparam logic [StatusW-1:0] StEqual   = 3'd4;

    // Serial divider geometry.
    localparam int DivDvdW = 49;
    localparam int DivDsrW = 33;
    localparam int DivQW   = 18;

    // Components in order: accel x/y/z, rate x/y/z, quat x/y/z/w.
    typedef logic [NComp-1:0][CompW-1:0] t_comps;

    typedef struct packed {
        logic              op;
        logic [StampW-1:0] stamp;
        t_comps            comps;
    } t_item;

    typedef struct packed {
        logic [StampW-1:0] stamp;
        t_comps            comps;
    } t_sample;

    typedef struct packed {
        logic [StatusW-1:0] status;
        t_comps             comps;
    } t_result;

    // Slot that lies k places after slot s in the circular store.
    function automatic logic [SlotW-1:0] slot_add(input logic [SlotW-1:0] s,
                                                  input logic [CountW-1:0] k);
        logic [CountW:0] sum;
        sum = (CountW + 1)'(s) + (CountW + 1)'(k);
        if (sum >= (CountW + 1)'(FifoDepth)) begin
            sum = sum - (CountW + 1)'(FifoDepth);
        end
        return sum[SlotW-1:0];
    endfunction

    // Saturate a 20-bit signed value to 16 bits.
    function automatic logic [CompW-1:0] sat16(input logic signed [19:0] v);
        logic [CompW-1:0] res;
        if (v > 20'sd32767) begin
            res = 16'h7fff;
        end else if (v < -20'sd32768) begin
            res = 16'h8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/imusti_in_if.sv
`default_nettype none
interface imusti_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [31:0]        stamp_us;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;

    modport source (output valid, op, stamp_us, accel_x, accel_y, accel_z, rate_x, rate_y,
                    rate_z, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink (input valid, op, stamp_us, accel_x, accel_y, accel_z, rate_x, rate_y,
                  rate_z, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface
`default_nettype wire

### rtl/imusti_out_if.sv
`default_nettype none
interface imusti_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [15:0] out_accel_x;
    logic signed [15:0] out_accel_y;
    logic signed [15:0] out_accel_z;
    logic signed [15:0] out_rate_x;
    logic signed [15:0] out_rate_y;
    logic signed [15:0] out_rate_z;
    logic signed [15:0] out_quat_x;
    logic signed [15:0] out_quat_y;
    logic signed [15:0] out_quat_z;
    logic signed [15:0] out_quat_w;

    modport source (output valid, status, out_accel_x, out_accel_y, out_accel_z, out_rate_x,
                    out_rate_y, out_rate_z, out_quat_x, out_quat_y, out_quat_z, out_quat_w,
                    input ready);
    modport sink (input valid, status, out_accel_x, out_accel_y, out_accel_z, out_rate_x,
                  out_rate_y, out_rate_z, out_quat_x, out_quat_y, out_quat_z, out_quat_w,
                  output ready);
endinterface
`default_nettype wire

### rtl/imu_sample_time_interpolator_top.sv
`default_nettype none
// IMU sample store with time-aligned read-out. A push beat stores one sample
// in a 16-entry circular store, dropping the oldest when full, and returns
// its status. A sync beat discards stale front samples, blends the oldest
// two with a Q2.16 weight and normalises the quaternion; a full blend uses
// the serial 18-bit divider for the weight and for each of four normalising
// divides, the 27-step square root, and the blend and sums of squares. A
// sync that finds no pair or equal stamps returns without a blend, and one
// whose blended quaternion is zero returns without the square root and the
// normalising divides. A two-beat input queue accepts beats, until it is
// full, while the sequencer works or a result waits. The gap limit register
// sits at byte address 0 of the APB port and resets to 200000 us.
module imu_sample_time_interpolator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    imusti_in_if.sink        i_in,
    imusti_out_if.source     o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [imusti_pkg::GapW-1:0] r_gap;
    logic                        item_valid;
    imusti_pkg::t_item           item;
    logic                        item_take;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= imusti_pkg::GapReset;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_gap <= pwdata[imusti_pkg::GapW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {8'b0, r_gap};

    imusti_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_item_valid(item_valid),
        .o_item      (item),
        .i_item_take (item_take)
    );

    imusti_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gap       (r_gap),
        .i_item_valid(item_valid),
        .i_item      (item),
        .o_item_take (item_take),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

### rtl/imusti_ram.sv
`default_nettype none
module imusti_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### rtl/imusti_front.sv
`default_nettype none
module imusti_front (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    imusti_in_if.sink     i_in,
    output logic          o_item_valid,
    output imusti_pkg::t_item o_item,
    input  wire logic     i_item_take
);

    imusti_pkg::t_item r_q [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    imusti_pkg::t_item in_item;
    logic              push;
    logic              pop;

    // Pack the incoming beat into one item word.
    always_comb begin
        in_item.op        = i_in.op;
        in_item.stamp     = i_in.stamp_us;
        in_item.comps[0]  = i_in.accel_x;
        in_item.comps[1]  = i_in.accel_y;
        in_item.comps[2]  = i_in.accel_z;
        in_item.comps[3]  = i_in.rate_x;
        in_item.comps[4]  = i_in.rate_y;
        in_item.comps[5]  = i_in.rate_z;
        in_item.comps[6]  = i_in.quat_x;
        in_item.comps[7]  = i_in.quat_y;
        in_item.comps[8]  = i_in.quat_z;
        in_item.comps[9]  = i_in.quat_w;
    end

    assign i_in.ready   = (r_cnt != 2'd2);
    assign push         = i_in.valid && i_in.ready;
    assign pop          = i_item_take && o_item_valid;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

    // Two-entry queue between the input channel and the sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= in_item;
                r_wp      <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

### rtl/imusti_div.sv
`default_nettype none
module imusti_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [imusti_pkg::DivDvdW-1:0]  i_dividend,
    input  wire logic [imusti_pkg::DivDsrW-1:0]  i_divisor,
    output logic                                 o_done,
    output logic [imusti_pkg::DivQW-1:0]         o_quot,
    output logic                                 o_ovf
);

    localparam int HiW = imusti_pkg::DivDvdW - imusti_pkg::DivQW;

    logic [imusti_pkg::DivDsrW:0]    r_rem;
    logic [imusti_pkg::DivQW-1:0]    r_low;
    logic [imusti_pkg::DivDsrW-1:0]  r_dsr;
    logic [4:0]                      r_cnt;
    logic                            r_busy;
    logic [imusti_pkg::DivDsrW:0]    trial;
    logic                            fits;

    assign trial = {r_rem[imusti_pkg::DivDsrW-1:0], r_low[imusti_pkg::DivQW-1]};
    assign fits  = (trial >= {1'b0, r_dsr});

    // Restoring division, one quotient bit a cycle. The quotient overflows
    // its width when the upper dividend bits already reach the divisor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_rem  <= (imusti_pkg::DivDsrW + 1)'(i_dividend[imusti_pkg::DivDvdW-1 -: HiW]);
                o_ovf  <= ((imusti_pkg::DivDsrW + 1)'(i_dividend[imusti_pkg::DivDvdW-1 -: HiW])
                          >= {1'b0, i_divisor});
                r_low  <= i_dividend[imusti_pkg::DivQW-1:0];
                r_dsr  <= i_divisor;
                r_cnt  <= 5'(imusti_pkg::DivQW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= fits ? (trial - {1'b0, r_dsr}) : trial;
                r_low  <= {r_low[imusti_pkg::DivQW-2:0], 1'b0};
                o_quot <= {o_quot[imusti_pkg::DivQW-2:0], fits};
                r_cnt  <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

### rtl/imusti_back.sv
`default_nettype none
module imusti_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [imusti_pkg::GapW-1:0]   i_gap,
    input  wire logic                          i_item_valid,
    input  wire imusti_pkg::t_item             i_item,
    output logic                               o_item_take,
    imusti_out_if.source                       o_out
);

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RD1, S_CHK, S_WSET, S_DIVW, S_MUL, S_ACC,
        S_SQ, S_SQACC, S_SQRT, S_NST, S_NDIV
    } t_state;

    t_state                              r_state, n_state;
    logic [imusti_pkg::SlotW-1:0]        r_oldest, n_oldest;
    logic [imusti_pkg::CountW-1:0]       r_count, n_count;
    logic [31:0]                         r_sync, n_sync;
    logic                                r_final, n_final;
    imusti_pkg::t_sample                 r_s0, n_s0, r_s1, n_s1;
    logic signed [17:0]                  r_w, n_w;
    logic [3:0]                          r_k, n_k;
    logic signed [39:0]                  r_prod, n_prod;
    logic signed [19:0]                  r_q [4];
    logic signed [19:0]                  n_q [4];
    logic [37:0]                         r_n2, n_n2;
    logic [53:0]                         r_v, n_v, r_r, n_r, r_b, n_b;
    logic                                r_neg, n_neg;
    imusti_pkg::t_result                 r_res, n_res;
    logic                                r_ovalid, n_ovalid;

    logic                                ram_we;
    logic [imusti_pkg::SlotW-1:0]        ram_waddr, ram_raddr;
    imusti_pkg::t_sample                 ram_wdata, ram_rdata;
    logic                                div_start, div_done, div_ovf;
    logic [imusti_pkg::DivDvdW-1:0]      div_dvd;
    logic [imusti_pkg::DivDsrW-1:0]      div_dsr;
    logic [imusti_pkg::DivQW-1:0]        div_q;

    // Datapath terms that the sequencer picks from.
    logic signed [32:0]                  num, den;
    logic [31:0]                         anum, aden;
    logic signed [15:0]                  a0, a1;
    logic signed [16:0]                  dif;
    logic signed [34:0]                  mw;
    logic signed [39:0]                  bsum;
    logic signed [19:0]                  qsel;
    logic signed [39:0]                  sq;
    logic [37:0]                         n2_sum;
    logic [53:0]                         rb;
    logic signed [43:0]                  nn;
    logic [43:0]                         nmag;
    logic [17:0]                         wneg;
    logic [17:0]                         qneg;
    logic                                out_free;

    assign num  = $signed({1'b0, r_sync}) - $signed({1'b0, r_s0.stamp});
    assign den  = $signed({1'b0, r_s1.stamp}) - $signed({1'b0, r_s0.stamp});
    assign anum = num[32] ? 32'(-num) : num[31:0];
    assign aden = den[32] ? 32'(-den) : den[31:0];
    assign a0   = $signed(r_s0.comps[r_k]);
    assign a1   = $signed(r_s1.comps[r_k]);
    assign dif  = $signed({a1[15], a1}) - $signed({a0[15], a0});
    assign mw   = dif * r_w;
    assign bsum = $signed({{8{a0[15]}}, a0, 16'b0}) + r_prod + 40'sd32768;
    assign qsel = r_q[r_k[1:0]];
    assign sq   = qsel * qsel;
    assign n2_sum = r_n2 + r_prod[37:0];
    assign rb   = r_r + r_b;
    assign nn   = $signed({{2{qsel[19]}}, qsel, 22'b0}) + $signed({18'b0, r_r[26:1]});
    assign nmag = 44'(-nn);
    assign wneg = ~div_q + 18'd1;
    assign qneg = ~div_q + 18'd1;
    assign out_free = !r_ovalid || o_out.ready;

    imusti_ram #(
        .Width(imusti_pkg::SampleW),
        .Depth(imusti_pkg::FifoDepth)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    imusti_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_dvd),
        .i_divisor (div_dsr),
        .o_done    (div_done),
        .o_quot    (div_q),
        .o_ovf     (div_ovf)
    );

    // Sequencer: one item at a time, from store access through the
    // weight divide, the blend, the norm and the final divides.
    always_comb begin
        n_state  = r_state;
        n_oldest = r_oldest;
        n_count  = r_count;
        n_sync   = r_sync;
        n_final  = r_final;
        n_s0     = r_s0;
        n_s1     = r_s1;
        n_w      = r_w;
        n_k      = r_k;
        n_prod   = r_prod;
        n_q      = r_q;
        n_n2     = r_n2;
        n_v      = r_v;
        n_r      = r_r;
        n_b      = r_b;
        n_neg    = r_neg;
        n_res    = r_res;
        n_ovalid = r_ovalid && !o_out.ready;
        o_item_take = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = imusti_pkg::slot_add(r_oldest, r_count);
        ram_wdata = {i_item.stamp, i_item.comps};
        ram_raddr = r_oldest;
        div_start = 1'b0;
        div_dvd   = '0;
        div_dsr   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_item_valid && out_free) begin
                    o_item_take = 1'b1;
                    n_res.comps = '0;
                    if (i_item.op == imusti_pkg::OpPush) begin
                        ram_we   = 1'b1;
                        n_ovalid = 1'b1;
                        if (r_count == imusti_pkg::CountW'(imusti_pkg::FifoDepth)) begin
                            ram_waddr    = r_oldest;
                            n_oldest     = imusti_pkg::slot_add(r_oldest,
                                                                imusti_pkg::CountW'(1));
                            n_res.status = imusti_pkg::StDropped;
                        end else begin
                            n_count      = r_count + imusti_pkg::CountW'(1);
                            n_res.status = imusti_pkg::StPushed;
                        end
                    end else begin
                        n_sync  = i_item.stamp;
                        n_final = 1'b0;
                        if (r_count < imusti_pkg::CountW'(2)) begin
                            n_res.status = imusti_pkg::StNoPair;
                            n_ovalid     = 1'b1;
                        end else begin
                            n_state = S_RD0;
                        end
                    end
                end
            end
            S_RD0: begin
                ram_raddr = r_oldest;
                n_state   = S_RD1;
            end
            S_RD1: begin
                ram_raddr = imusti_pkg::slot_add(r_oldest, imusti_pkg::CountW'(1));
                n_s0      = ram_rdata;
                n_state   = S_CHK;
            end
            S_CHK: begin
                n_s1 = ram_rdata;
                if (r_final) begin
                    n_state = S_WSET;
                end else if (r_s0.stamp > r_sync) begin
                    n_res.status = imusti_pkg::StNoPair;
                    n_ovalid     = 1'b1;
                    n_state      = S_IDLE;
                end else if (ram_rdata.stamp < r_sync ||
                             (r_sync - r_s0.stamp) > 32'(i_gap) ||
                             (ram_rdata.stamp - r_sync) > 32'(i_gap)) begin
                    // Drop the front; a gap violation stops further discards.
                    n_oldest = imusti_pkg::slot_add(r_oldest, imusti_pkg::CountW'(1));
                    n_count  = r_count - imusti_pkg::CountW'(1);
                    if (!(ram_rdata.stamp < r_sync)) begin
                        n_final = 1'b1;
                    end
                    if (r_count < imusti_pkg::CountW'(3)) begin
                        n_res.status = imusti_pkg::StNoPair;
                        n_ovalid     = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_RD0;
                    end
                end else begin
                    n_state = S_WSET;
                end
            end
            S_WSET: begin
                if (den == 33'sd0) begin
                    n_res.status = imusti_pkg::StEqual;
                    n_ovalid     = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    div_start = 1'b1;
                    div_dvd   = {1'b0, anum, 16'b0} + {18'b0, aden[31:1]};
                    div_dsr   = {1'b0, aden};
                    n_neg     = num[32] ^ den[32];
                    n_n2      = '0;
                    n_state   = S_DIVW;
                end
            end
            S_DIVW: begin
                if (div_done) begin
                    if (r_neg) begin
                        n_w = (div_ovf || div_q > 18'd131072) ? $signed(18'h20000)
                                                               : $signed(wneg);
                    end else begin
                        n_w = (div_ovf || div_q > 18'd131071) ? 18'sd131071 : $signed(div_q);
                    end
                    n_k     = 4'd0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = {{5{mw[34]}}, mw};
                n_state = S_ACC;
            end
            S_ACC: begin
                if (r_k < 4'd6) begin
                    n_res.comps[r_k] = imusti_pkg::sat16(bsum[35:16]);
                end else begin
                    n_q[2'(r_k - 4'd6)] = bsum[35:16];
                end
                if (r_k == 4'd9) begin
                    n_k     = 4'd0;
                    n_state = S_SQ;
                end else begin
                    n_k     = r_k + 4'd1;
                    n_state = S_MUL;
                end
            end
            S_SQ: begin
                n_prod  = sq;
                n_state = S_SQACC;
            end
            S_SQACC: begin
                n_n2 = n2_sum;
                if (r_k == 4'd3) begin
                    n_k = 4'd0;
                    if (n2_sum == '0) begin
                        n_res.comps[9:6] = '0;
                        n_res.status     = imusti_pkg::StSynced;
                        n_ovalid         = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        n_v     = {n2_sum, 16'b0};
                        n_r     = '0;
                        n_b     = 54'd1 << 52;
                        n_state = S_SQRT;
                    end
                end else begin
                    n_k     = r_k + 4'd1;
                    n_state = S_SQ;
                end
            end
            S_SQRT: begin
                // One result bit of the integer square root a cycle.
                if (r_v >= rb) begin
                    n_v = r_v - rb;
                    n_r = (r_r >> 1) + r_b;
                end else begin
                    n_r = r_r >> 1;
                end
                n_b = r_b >> 2;
                if (r_b[0]) begin
                    n_state = S_NST;
                end
            end
            S_NST: begin
                div_start = 1'b1;
                div_dsr   = {6'b0, r_r[26:0]};
                n_neg     = nn[43];
                if (nn[43]) begin
                    div_dvd = {5'b0, nmag} + {22'b0, r_r[26:0]} - 49'd1;
                end else begin
                    div_dvd = {5'b0, nn};
                end
                n_state = S_NDIV;
            end
            S_NDIV: begin
                if (div_done) begin
                    if (r_neg) begin
                        n_res.comps[r_k + 4'd6] =
                            (div_ovf || div_q > 18'd32768) ? 16'h8000 : qneg[15:0];
                    end else begin
                        n_res.comps[r_k + 4'd6] =
                            (div_ovf || div_q > 18'd32767) ? 16'h7fff : div_q[15:0];
                    end
                    if (r_k == 4'd3) begin
                        n_res.status = imusti_pkg::StSynced;
                        n_ovalid     = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_k     = r_k + 4'd1;
                        n_state = S_NST;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_oldest <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_oldest <= n_oldest;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_sync  <= n_sync;
        r_final <= n_final;
        r_s0    <= n_s0;
        r_s1    <= n_s1;
        r_w     <= n_w;
        r_k     <= n_k;
        r_prod  <= n_prod;
        r_q     <= n_q;
        r_n2    <= n_n2;
        r_v     <= n_v;
        r_r     <= n_r;
        r_b     <= n_b;
        r_neg   <= n_neg;
        r_res   <= n_res;
    end

    // Result register drives the output channel.
    assign o_out.valid       = r_ovalid;
    assign o_out.status      = r_res.status;
    assign o_out.out_accel_x = $signed(r_res.comps[0]);
    assign o_out.out_accel_y = $signed(r_res.comps[1]);
    assign o_out.out_accel_z = $signed(r_res.comps[2]);
    assign o_out.out_rate_x  = $signed(r_res.comps[3]);
    assign o_out.out_rate_y  = $signed(r_res.comps[4]);
    assign o_out.out_rate_z  = $signed(r_res.comps[5]);
    assign o_out.out_quat_x  = $signed(r_res.comps[6]);
    assign o_out.out_quat_y  = $signed(r_res.comps[7]);
    assign o_out.out_quat_z  = $signed(r_res.comps[8]);
    assign o_out.out_quat_w  = $signed(r_res.comps[9]);

endmodule
`default_nettype wire

### rtl/imusti_checker.sv
`default_nettype none
module imusti_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  i_status,
    input wire logic [159:0] i_data,
    input wire logic        i_psel,
    input wire logic        i_penable,
    input wire logic        i_pwrite,
    input wire logic [2:0]  i_paddr,
    input wire logic [31:0] i_pwdata,
    input wire logic [31:0] i_prdata
);

    // A result beat stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat withdrawn");

    // Only a synced result carries data.
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != imusti_pkg::StSynced |-> i_data == '0)
        else $error("non-zero data on a result that is not synced");

    // The input queue is empty, hence ready, straight after reset.
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

    // A gap limit write reads back on the next cycle.
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite && !i_paddr[2]
        |=> i_paddr[2] || i_prdata == {8'b0, $past(i_pwdata[23:0])})
        else $error("gap limit read-back mismatch");

endmodule

bind imu_sample_time_interpolator_top imusti_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_status   (o_out.status),
    .i_data     ({o_out.out_accel_x, o_out.out_accel_y, o_out.out_accel_z,
                  o_out.out_rate_x, o_out.out_rate_y, o_out.out_rate_z,
                  o_out.out_quat_x, o_out.out_quat_y, o_out.out_quat_z,
                  o_out.out_quat_w}),
    .i_psel     (psel),
    .i_penable  (penable),
    .i_pwrite   (pwrite),
    .i_paddr    (paddr),
    .i_pwdata   (pwdata),
    .i_prdata   (prdata)
);
`default_nettype wire
